[sv/gradient_threshold_edge_map_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the gradient threshold edge map block
// Clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_THRESHOLD_EDGE_MAP_TOP_ASSERT_SVH
`define GRADIENT_THRESHOLD_EDGE_MAP_TOP_ASSERT_SVH

// Same-cycle implication.
`define GTEM_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication.
`define GTEM_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

[sv/gtem_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtem_pkg
// Shared types, constants and helpers of the gradient threshold edge map.
// ----------------------------------------------------------------------------
package gtem_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int GREY_W      = 8;
    localparam int THRESH_W    = 8;
    localparam int DIM_W       = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [THRESH_W-1:0] THRESH_RESET = '0;
    localparam logic [DIM_W-1:0]    DIM_RESET    = 11'd1024;

    localparam logic [GREY_W-1:0] EDGE_VALUE       = 8'd0;
    localparam logic [GREY_W-1:0] BACKGROUND_VALUE = 8'd255;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_THRESHOLD    = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2
    } cfg_reg_e;

    // Per-transaction flags handed from the front to the back
    typedef struct packed {
        logic wr_en;      // carries a pixel of the frame
        logic raw_valid;  // raw mark one line back gets computed
        logic below_ok;   // that pixel has a lower row
        logic side_ok;    // that pixel has a lower column
        logic out_valid;  // a result leaves for two lines back
        logic interior;   // that result pixel is off the border
        logic last;       // final pixel of the frame
    } op_flags_t;

    function automatic logic diff_exceeds(input logic [GREY_W-1:0]   a,
                                          input logic [GREY_W-1:0]   b,
                                          input logic [THRESH_W-1:0] th);
        logic [GREY_W-1:0] d;
        begin
            d = (a > b) ? (a - b) : (b - a);
            return d > th;
        end
    endfunction

endpackage

[sv/gtem_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtem_pixel_if / gtem_result_if
// Valid/ready channels for incoming pixels and outgoing map values.
// ----------------------------------------------------------------------------
interface gtem_pixel_if;
    import gtem_pkg::*;

    logic              valid;
    logic              ready;
    logic [GREY_W-1:0] grey_pixel;
    logic              flush;

    modport source (output valid, output grey_pixel, output flush, input ready);
    modport sink   (input valid, input grey_pixel, input flush, output ready);
endinterface

interface gtem_result_if;
    import gtem_pkg::*;

    logic              valid;
    logic              ready;
    logic [GREY_W-1:0] out_value;
    logic              frame_last;

    modport source (output valid, output out_value, output frame_last, input ready);
    modport sink   (input valid, input out_value, input frame_last, output ready);
endinterface

[sv/gtem_front.sv]
`timescale 1ns / 1ps
`include "gradient_threshold_edge_map_top_assert.svh"
// ----------------------------------------------------------------------------
// gtem_front
// Tracks the scan position, latches frame size and classifies transactions.
// ----------------------------------------------------------------------------
module gtem_front #(
    parameter int MAX_WIDTH  = gtem_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gtem_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    gtem_pixel_if.sink                          pixel,
    input  logic [gtem_pkg::DIM_W-1:0]          image_width,
    input  logic [gtem_pkg::DIM_W-1:0]          image_height,
    output logic                                op_valid,
    input  logic                                op_ready,
    output logic [gtem_pkg::GREY_W-1:0]         op_grey,
    output logic [$clog2(MAX_WIDTH)-1:0]        op_addr,
    output logic [$clog2(MAX_WIDTH)-1:0]        op_raddr,
    output gtem_pkg::op_flags_t                 op_flags
);
    import gtem_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT + 2);
    localparam int CMPW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
    localparam int CMPH = (RW > DIM_W) ? RW : DIM_W;

    logic [CW-1:0] in_col_reg, in_col_next;
    logic [RW-1:0] in_row_reg, in_row_next;
    logic [CW-1:0] wm1_reg, wm1_next;
    logic [RW-1:0] h_reg, h_next;

    logic [CMPW-1:0] wide_w;
    logic [CMPH-1:0] wide_h;
    logic [CW-1:0]   wm1_cfg, wm1_cur;
    logic [RW-1:0]   h_cfg, h_cur, h_plus1;
    logic            start, accept, drop, push, col_end;

    // Clamp the configured size into [2, MAX]
    always_comb
    begin
        wide_w = CMPW'(image_width);
        wide_h = CMPH'(image_height);
        if (wide_w < CMPW'(2))
            wm1_cfg = CW'(1);
        else if (wide_w > CMPW'(MAX_WIDTH))
            wm1_cfg = CW'(MAX_WIDTH - 1);
        else
            wm1_cfg = CW'(wide_w - CMPW'(1));
        if (wide_h < CMPH'(2))
            h_cfg = RW'(2);
        else if (wide_h > CMPH'(MAX_HEIGHT))
            h_cfg = RW'(MAX_HEIGHT);
        else
            h_cfg = RW'(wide_h);
    end

    assign start   = (in_row_reg == '0) && (in_col_reg == '0);
    assign wm1_cur = start ? wm1_cfg : wm1_reg;
    assign h_cur   = start ? h_cfg : h_reg;
    assign h_plus1 = RW'(h_cur + 1'b1);
    assign col_end = (in_col_reg == wm1_cur);

    assign pixel.ready = op_ready;
    assign accept      = pixel.valid && op_ready;
    // Flush before the frame is complete carries nothing
    assign drop        = pixel.flush && (in_row_reg < h_cur);
    assign push        = accept && !drop;

    always_comb
    begin
        op_flags.wr_en     = in_row_reg < h_cur;
        op_flags.raw_valid = (in_row_reg >= RW'(1)) && (in_row_reg <= h_cur);
        op_flags.below_ok  = in_row_reg < h_cur;
        op_flags.side_ok   = in_col_reg < wm1_cur;
        op_flags.out_valid = in_row_reg >= RW'(2);
        op_flags.interior  = (in_row_reg >= RW'(3)) && (in_row_reg <= h_cur)
                             && (in_col_reg != '0) && (in_col_reg < wm1_cur);
        op_flags.last      = (in_row_reg == h_plus1) && col_end;
    end

    assign op_valid = push;
    assign op_grey  = pixel.grey_pixel;
    assign op_addr  = in_col_reg;
    assign op_raddr = col_end ? '0 : CW'(in_col_reg + 1'b1);

    always_comb
    begin
        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        wm1_next    = wm1_reg;
        h_next      = h_reg;
        if (push)
        begin
            wm1_next = wm1_cur;
            h_next   = h_cur;
            if (op_flags.last)
            begin
                in_col_next = '0;
                in_row_next = '0;
            end
            else if (col_end)
            begin
                in_col_next = '0;
                in_row_next = RW'(in_row_reg + 1'b1);
            end
            else
            begin
                in_col_next = CW'(in_col_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg <= '0;
            in_row_reg <= '0;
            wm1_reg    <= CW'(1);
            h_reg      <= RW'(2);
        end
        else
        begin
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
            wm1_reg    <= wm1_next;
            h_reg      <= h_next;
        end
    end

    `GTEM_ASSERT_NEXT(a_drop_holds_position, accept && drop,
        $stable(in_col_reg) && $stable(in_row_reg), "dropped flush moved the scan position")
    `GTEM_ASSERT_NEXT(a_last_restarts_frame, push && op_flags.last,
        (in_row_reg == '0) && (in_col_reg == '0), "frame did not restart after last pixel")

endmodule

[sv/gtem_queue.sv]
`timescale 1ns / 1ps
`include "gradient_threshold_edge_map_top_assert.svh"
// ----------------------------------------------------------------------------
// gtem_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module gtem_queue #(
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output logic [DATA_W-1:0] head_data
);
    import gtem_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : PTR_W'(wr_ptr_reg + 1'b1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : PTR_W'(rd_ptr_reg + 1'b1);
        if (do_push && !do_pop)
            count_next = CNT_W'(count_reg + 1'b1);
        else if (do_pop && !do_push)
            count_next = CNT_W'(count_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    `GTEM_ASSERT_NEXT(a_count_tracks_push, do_push && !do_pop,
        count_reg == CNT_W'($past(count_reg) + 1'b1), "queue count missed a push")

endmodule

[sv/gtem_back.sv]
`timescale 1ns / 1ps
`include "gradient_threshold_edge_map_top_assert.svh"
// ----------------------------------------------------------------------------
// gtem_back
// Line buffers, raw gradient marks, in-place cleanup and the result register.
// ----------------------------------------------------------------------------
module gtem_back #(
    parameter int MAX_WIDTH = gtem_pkg::DEF_MAX_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [gtem_pkg::THRESH_W-1:0]  threshold,
    input  logic                           op_valid,
    output logic                           op_pop,
    input  logic [gtem_pkg::GREY_W-1:0]    op_grey,
    input  logic [$clog2(MAX_WIDTH)-1:0]   op_addr,
    input  logic [$clog2(MAX_WIDTH)-1:0]   op_raddr,
    input  gtem_pkg::op_flags_t            op_flags,
    gtem_result_if.source                  result
);
    import gtem_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    // Line memories, one slot per column
    logic [GREY_W-1:0] grey_mem  [MAX_WIDTH];
    logic              edge_mem  [MAX_WIDTH];
    logic              clean_mem [MAX_WIDTH];

    logic              adv, s1_adv, s2_adv;

    logic              s1_valid_reg;
    op_flags_t         s1_flags_reg;
    logic [CW-1:0]     s1_addr_reg, s1_raddr_reg;
    logic [GREY_W-1:0] s1_side_reg, s1_g_reg, s1_below_reg;

    logic              s2_valid_reg;
    op_flags_t         s2_flags_reg;
    logic [CW-1:0]     s2_addr_reg;
    logic              s2_down_reg, s2_left_reg, s2_v_reg, s2_up_reg;

    logic              res_valid_reg;
    logic [GREY_W-1:0] out_value_reg;
    logic              frame_last_reg;
    logic              right_reg;

    logic [GREY_W-1:0] below, side;
    logic              raw, clean;

    // Whole pipeline moves when the result register can take a value
    assign adv    = !res_valid_reg || result.ready;
    assign op_pop = adv && op_valid;
    assign s1_adv = adv && s1_valid_reg;
    assign s2_adv = adv && s2_valid_reg;

    always_comb
    begin
        below = s1_flags_reg.below_ok ? s1_below_reg : s1_g_reg;
        side  = s1_flags_reg.side_ok ? s1_side_reg : s1_g_reg;
        raw   = diff_exceeds(s1_g_reg, below, threshold)
                || diff_exceeds(s1_g_reg, side, threshold);
    end

    always_comb
    begin
        clean = s2_v_reg;
        if (s2_flags_reg.interior)
        begin
            if (s2_v_reg && !s2_up_reg && !s2_down_reg && !s2_left_reg && !right_reg)
                clean = 1'b0;
            else if (!s2_v_reg && s2_up_reg && s2_down_reg && s2_left_reg && right_reg)
                clean = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= op_valid;
            s2_valid_reg  <= s1_valid_reg;
            res_valid_reg <= s2_valid_reg && s2_flags_reg.out_valid;
        end
    end

    // Grey line: write this column, fetch the next column one line back
    always_ff @(posedge clk)
    begin
        if (op_pop)
        begin
            if (op_flags.wr_en)
                grey_mem[op_addr] <= op_grey;
            s1_side_reg  <= grey_mem[op_raddr];
            s1_g_reg     <= s1_side_reg;
            s1_below_reg <= op_grey;
            s1_flags_reg <= op_flags;
            s1_addr_reg  <= op_addr;
            s1_raddr_reg <= op_raddr;
        end
    end

    // Raw mark line
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            if (s1_flags_reg.raw_valid)
                edge_mem[s1_addr_reg] <= raw;
            s2_left_reg  <= edge_mem[s1_raddr_reg];
            s2_v_reg     <= s2_left_reg;
            s2_down_reg  <= raw;
            s2_flags_reg <= s1_flags_reg;
            s2_addr_reg  <= s1_addr_reg;
        end
    end

    // Cleaned mark line: read one line back, write the fresh result
    always_ff @(posedge clk)
    begin
        if (s2_adv && s2_flags_reg.out_valid)
            clean_mem[s2_addr_reg] <= clean;
        if (s1_adv)
            s2_up_reg <= clean_mem[s1_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv && s2_flags_reg.out_valid)
        begin
            out_value_reg  <= clean ? EDGE_VALUE : BACKGROUND_VALUE;
            frame_last_reg <= s2_flags_reg.last;
            right_reg      <= clean;
        end
    end

    assign result.valid      = res_valid_reg;
    assign result.out_value  = out_value_reg;
    assign result.frame_last = frame_last_reg;

    `GTEM_ASSERT_NEXT(a_stalled_stage_holds, s1_valid_reg && !adv,
        s1_valid_reg, "stalled stage lost its transaction")

endmodule

[sv/gradient_threshold_edge_map_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_threshold_edge_map_top
// Streams a grey frame and returns a cleaned threshold gradient edge map.
// ----------------------------------------------------------------------------
// Usage:
//   pixel channel: one grey pixel per transaction in reverse scan order (last
//   row first, last column first). flush transactions carry no pixel; after
//   the W*H pixels send 2*W more transactions (flush or not) to drain.
//   result channel: one value per pixel in the same order, 0 for edge and 255
//   for background, frame_last set on the final pixel of the frame.
//   Config port: cfg_we writes threshold, image_width or image_height by
//   cfg_index; write only while idle. Size is latched at the first pixel.
// Throughput and delay:
//   One transaction per cycle sustained while result.ready stays high. The result
//   for pixel k leaves with transaction k+2*W through the queue, stage 1, stage 2
//   and the result register; the line memories (one slot per column) set the
//   two-line delay. A flush before the frame is complete is taken and dropped.
// Reset and stalls:
//   Reset clears positions, config registers and pipeline valids; line
//   memories need no clearing. A stalled receiver holds the result register,
//   the four-entry queue fills, then pixel.ready drops.
// ----------------------------------------------------------------------------
module gradient_threshold_edge_map_top #(
    parameter int MAX_WIDTH  = gtem_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gtem_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    gtem_pixel_if.sink                        pixel,
    gtem_result_if.source                     result,
    input  logic                              cfg_we,
    input  logic [gtem_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [gtem_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import gtem_pkg::*;

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int FIFO_W = GREY_W + 2 * CW + $bits(op_flags_t);

    logic [THRESH_W-1:0] threshold_reg;
    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;

    logic                front_valid, front_ready;
    logic [GREY_W-1:0]   front_grey;
    logic [CW-1:0]       front_addr, front_raddr;
    op_flags_t           front_flags;

    logic                q_full, q_valid, q_pop;
    logic [FIFO_W-1:0]   q_data;
    logic [GREY_W-1:0]   back_grey;
    logic [CW-1:0]       back_addr, back_raddr;
    op_flags_t           back_flags;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESH_RESET;
            width_reg     <= DIM_RESET;
            height_reg    <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD:    threshold_reg <= cfg_data[THRESH_W-1:0];
                CFG_IMAGE_WIDTH:  width_reg     <= cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg    <= cfg_data[DIM_W-1:0];
                default:          ;
            endcase
        end
    end

    gtem_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel        (pixel),
        .image_width  (width_reg),
        .image_height (height_reg),
        .op_valid     (front_valid),
        .op_ready     (front_ready),
        .op_grey      (front_grey),
        .op_addr      (front_addr),
        .op_raddr     (front_raddr),
        .op_flags     (front_flags)
    );

    assign front_ready = !q_full;

    gtem_queue #(
        .DATA_W (FIFO_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_valid),
        .push_data  ({front_grey, front_addr, front_raddr, front_flags}),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_data)
    );

    assign {back_grey, back_addr, back_raddr, back_flags} = q_data;

    gtem_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .threshold (threshold_reg),
        .op_valid  (q_valid),
        .op_pop    (q_pop),
        .op_grey   (back_grey),
        .op_addr   (back_addr),
        .op_raddr  (back_raddr),
        .op_flags  (back_flags),
        .result    (result)
    );

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the gradient threshold edge map. A scoreboard
// model tracks the pixel rings, raw gradient marks and cleaned marks, and it
// predicts every map value when the transaction two lines after its pixel is accepted.
// Named tests cover dropped flushes, drain pixels, border self-compare,
// cleaning of lone marks and holes, threshold and size extremes, stalls on
// both sides and random frames.
// ----------------------------------------------------------------------------
module tb_top;
    import gtem_pkg::*;

    localparam int RING_LEN      = 2 * DEF_MAX_WIDTH;
    localparam int RANDOM_ITEMS  = 250;
    localparam int CYCLE_LIMIT   = 40000;
    localparam int SETTLE_CYCLES = 12;
    localparam int IDLE_PCT      = 15;
    localparam int NO_PAUSE      = -1;

    typedef enum int {
        PAT_RANDOM,
        PAT_EXTREMES,
        PAT_FLAT,
        PAT_NOISY_RAMP,
        PAT_BUMP,
        PAT_HOLE
    } pattern_e;

    typedef struct {
        logic [GREY_W-1:0] value;
        logic              last;
    } map_value_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    gtem_pixel_if  pix_ch ();
    gtem_result_if res_ch ();

    gradient_threshold_edge_map_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pix_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Scoreboard copy of the block state
    logic [GREY_W-1:0]   grey_ring [RING_LEN];
    bit                  raw_ring [RING_LEN];
    bit                  clean_ring [RING_LEN];
    int unsigned         in_pos = 0;
    int unsigned         frame_w = 2;
    int unsigned         frame_h = 2;
    logic [THRESH_W-1:0] thr_reg = THRESH_RESET;
    logic [DIM_W-1:0]    width_reg = DIM_RESET;
    logic [DIM_W-1:0]    height_reg = DIM_RESET;

    map_value_t  expected_map [$];
    int unsigned fail_count = 0;
    int unsigned values_checked = 0;
    int unsigned transactions_sent = 0;
    int unsigned frame_items = 0;
    int unsigned frames_done = 0;
    int unsigned frame_level = 0;
    bit          steady = 1'b0;
    int unsigned hold_request = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int unsigned fit_dim(input int unsigned v, input int unsigned maxv);
        if (v < 2)
            return 2;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    function automatic void mark_gradient(input int unsigned j);
        int unsigned row, col;
        int          g, below, side;
        row   = frame_h - 1 - j / frame_w;
        col   = frame_w - 1 - j % frame_w;
        g     = grey_ring[j % RING_LEN];
        // bottom row and first column compare against the pixel itself
        below = (row > 0) ? int'(grey_ring[(j + frame_w) % RING_LEN]) : g;
        side  = (col > 0) ? int'(grey_ring[(j + 1) % RING_LEN]) : g;
        raw_ring[j % RING_LEN] = (((g > below) ? g - below : below - g) > int'(thr_reg)) ||
                                 (((g > side) ? g - side : side - g) > int'(thr_reg));
    endfunction

    function automatic bit clean_mark(input int unsigned k);
        int unsigned row, col;
        bit          v, up, down, left, right;
        row = frame_h - 1 - k / frame_w;
        col = frame_w - 1 - k % frame_w;
        v   = raw_ring[k % RING_LEN];
        if (row > 0 && row < frame_h - 1 && col > 0 && col < frame_w - 1)
        begin
            // upper and right neighbors are already cleaned, the others are raw
            up    = clean_ring[(k - frame_w) % RING_LEN];
            down  = raw_ring[(k + frame_w) % RING_LEN];
            left  = raw_ring[(k + 1) % RING_LEN];
            right = clean_ring[(k - 1) % RING_LEN];
            if (v && !up && !down && !left && !right)
                v = 1'b0;
            else if (!v && up && down && left && right)
                v = 1'b1;
        end
        clean_ring[k % RING_LEN] = v;
        return v;
    endfunction

    task automatic predict_map_value(input logic [GREY_W-1:0] grey, input logic is_flush);
        int unsigned total, t, k;
        map_value_t  item;
        if (in_pos == 0)
        begin
            if (is_flush)
                return;
            frame_w = fit_dim(width_reg, DEF_MAX_WIDTH);
            frame_h = fit_dim(height_reg, DEF_MAX_HEIGHT);
        end
        total = frame_w * frame_h;
        t     = in_pos;
        if (t < total)
        begin
            // drop a flush that comes before the frame is complete
            if (is_flush)
                return;
            grey_ring[t % RING_LEN] = grey;
        end
        in_pos = t + 1;
        if (t >= frame_w && t - frame_w < total)
            mark_gradient(t - frame_w);
        if (t >= 2 * frame_w)
        begin
            k          = t - 2 * frame_w;
            item.value = clean_mark(k) ? EDGE_VALUE : BACKGROUND_VALUE;
            item.last  = (k == total - 1);
            expected_map.push_back(item);
            if (item.last)
                in_pos = 0;
        end
    endtask

    function automatic logic [GREY_W-1:0] pattern_pixel(input pattern_e pat,
                                                        input int unsigned row, col, w, h);
        int v;
        case (pat)
            PAT_RANDOM:   v = $urandom_range(255);
            PAT_EXTREMES: v = $urandom_range(1) ? 255 : 0;
            PAT_FLAT:     v = frame_level;
            PAT_NOISY_RAMP:
                v = ($urandom_range(99) < 5) ? $urandom_range(255)
                                             : frame_level + 3 * row + 2 * col + $urandom_range(6);
            // one pixel lifted above a gentle ramp leaves a lone interior edge mark
            PAT_BUMP:     v = 5 * row + ((row == h / 2 && col == w / 2) ? 10 : 0);
            // checkerboard whose center copies its lower neighbors: a hole among edges
            PAT_HOLE:     v = (((row + col) % 2 == 1) != (row == h / 2 && col == w / 2)) ? 200 : 0;
            default:      v = 0;
        endcase
        return GREY_W'(v);
    endfunction

    task automatic send_item(input logic [GREY_W-1:0] grey, input logic is_flush);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            pix_ch.valid <= 1'b0;
            @(negedge clk);
        end
        pix_ch.valid      <= 1'b1;
        pix_ch.grey_pixel <= grey;
        pix_ch.flush      <= is_flush;
        do @(posedge clk); while (!pix_ch.ready);
        predict_map_value(grey, is_flush);
        transactions_sent++;
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        pix_ch.valid <= 1'b0;
        do @(negedge clk); while (expected_map.size() != 0);
    endtask

    task automatic write_reg(input cfg_reg_e idx, input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_THRESHOLD:    thr_reg = THRESH_W'(value);
            CFG_IMAGE_WIDTH:  width_reg = DIM_W'(value);
            CFG_IMAGE_HEIGHT: height_reg = DIM_W'(value);
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic configure(input int unsigned thr, input int unsigned w, input int unsigned h);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
    endtask

    // Stream one frame plus its two drain lines, then settle until the block is idle
    task automatic run_frame(input pattern_e pat, input int noise_pct,
                             input int drain_pixel_pct, input int pause_at);
        int unsigned w, h;
        w           = fit_dim(width_reg, DEF_MAX_WIDTH);
        h           = fit_dim(height_reg, DEF_MAX_HEIGHT);
        frame_level = $urandom_range(255);
        for (int unsigned j = 0; j < w * h; j++)
        begin
            if (int'(j) == pause_at)
                wait_for_results();
            if ($urandom_range(99) < noise_pct)
                send_item(GREY_W'($urandom_range(255)), 1'b1);
            send_item(pattern_pixel(pat, h - 1 - j / w, w - 1 - j % w, w, h), 1'b0);
        end
        for (int unsigned d = 0; d < 2 * w; d++)
            send_item(GREY_W'($urandom_range(255)), $urandom_range(99) >= drain_pixel_pct);
        frame_items += w * h + 2 * w;
        frames_done++;
        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic test_dropped_flush();
        configure(0, 3, 2);
        repeat (3) send_item(8'hA5, 1'b1);
        run_frame(PAT_RANDOM, 40, 0, NO_PAUSE);
        // drain lines carry pixels whose grey values must be ignored
        run_frame(PAT_RANDOM, 0, 100, NO_PAUSE);
    endtask

    task automatic test_threshold_extremes();
        configure(0, 2, 2);
        run_frame(PAT_FLAT, 0, 50, NO_PAUSE);
        configure(0, 4, 3);
        run_frame(PAT_EXTREMES, 0, 50, NO_PAUSE);
        configure(255, 4, 3);
        run_frame(PAT_EXTREMES, 0, 50, NO_PAUSE);
    endtask

    task automatic test_lone_mark_cleared();
        configure(10, 6, 6);
        run_frame(PAT_BUMP, 0, 0, NO_PAUSE);
    endtask

    task automatic test_hole_filled();
        configure(100, 6, 6);
        run_frame(PAT_HOLE, 0, 0, NO_PAUSE);
    endtask

    task automatic test_size_limits();
        configure(128, 0, 1);
        run_frame(PAT_RANDOM, 0, 50, NO_PAUSE);
        configure(40, 40, 2);
        run_frame(PAT_NOISY_RAMP, 0, 50, NO_PAUSE);
        configure(40, 2, 10);
        run_frame(PAT_NOISY_RAMP, 0, 50, NO_PAUSE);
    endtask

    task automatic test_full_rate();
        steady = 1'b1;
        configure(60, 16, 8);
        run_frame(PAT_RANDOM, 0, 50, NO_PAUSE);
        run_frame(PAT_NOISY_RAMP, 0, 50, NO_PAUSE);
        steady = 1'b0;
    endtask

    task automatic test_receiver_hold();
        configure(90, 10, 6);
        steady       = 1'b1;
        hold_request = 300;
        run_frame(PAT_RANDOM, 5, 50, NO_PAUSE);
        steady = 1'b0;
    endtask

    task automatic test_sender_pause();
        configure(80, 8, 8);
        run_frame(PAT_RANDOM, 0, 50, 40);
    endtask

    task automatic test_random_frames();
        int unsigned start_items;
        start_items = frame_items;
        while (frame_items - start_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(99) < 70)
            begin
                case ($urandom_range(9))
                    0:       write_reg(CFG_THRESHOLD, 0);
                    1:       write_reg(CFG_THRESHOLD, 255);
                    default: write_reg(CFG_THRESHOLD, $urandom_range(255));
                endcase
            end
            if ($urandom_range(99) < 70 || width_reg > 40)
                write_reg(CFG_IMAGE_WIDTH, ($urandom_range(9) == 0) ? $urandom_range(11, 40)
                                                                    : $urandom_range(2, 10));
            if ($urandom_range(99) < 70 || height_reg > 10)
                write_reg(CFG_IMAGE_HEIGHT, $urandom_range(2, 10));
            run_frame(pattern_e'($urandom_range(PAT_HOLE)), $urandom_range(10),
                      $urandom_range(100), NO_PAUSE);
        end
    endtask

    // Receiver: random ready, or a counted hold-off when one is requested
    initial
    begin : map_receiver
        int unsigned hold_left;
        hold_left = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                res_ch.ready <= steady || $urandom_range(99) >= IDLE_PCT;
        end
    end

    always @(posedge clk)
    begin : map_checker
        map_value_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_map.size() == 0)
            begin
                $error("unexpected map value: out_value %0d, frame_last %0d",
                       res_ch.out_value, res_ch.frame_last);
                fail_count++;
            end
            else
            begin
                want = expected_map.pop_front();
                values_checked++;
                if (res_ch.out_value !== want.value)
                begin
                    $error("out_value: expected %0d, got %0d", want.value, res_ch.out_value);
                    fail_count++;
                end
                if (res_ch.frame_last !== want.last)
                begin
                    $error("frame_last: expected %0d, got %0d", want.last, res_ch.frame_last);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("gradient_threshold_edge_map_top regression: fail");
        $finish;
    end

    initial
    begin : test_sequence
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_THRESHOLD;
        cfg_data          <= '0;
        pix_ch.valid      <= 1'b0;
        pix_ch.grey_pixel <= '0;
        pix_ch.flush      <= 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_dropped_flush();
        test_threshold_extremes();
        test_lone_mark_cleared();
        test_hole_filled();
        test_size_limits();
        test_full_rate();
        test_receiver_hold();
        test_sender_pause();
        test_random_frames();

        wait_for_results();
        repeat (20) @(negedge clk);
        $display("covered %0d frames (sizes 2x2 up to 40 wide and 10 tall), %0d transactions",
                 frames_done, transactions_sent);
        $display("checked %0d map values under idling, a long result stall and a sender pause",
                 values_checked);
        if (fail_count == 0)
            $display("gradient_threshold_edge_map_top regression: pass");
        else
            $display("gradient_threshold_edge_map_top regression: fail");
        $finish;
    end

endmodule
